### hdl/mlp_pkg.sv
// Shared types and codes for the multilayer perceptron inference block.
package mlp_pkg;

  localparam int VAL_W = 16;
  localparam int ACC_W = 40;
  localparam int ACT_W = 13;
  localparam int SIZE_W = 5;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] REQ_WEIGHT = 2'd0;
  localparam logic [1:0] REQ_BIAS   = 2'd1;
  localparam logic [1:0] REQ_INPUT  = 2'd2;
  localparam logic [1:0] REQ_RUN    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_SIZE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIDDEN_LAYERS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIDDEN1_SIZE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIDDEN2_SIZE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SIZE   = 3'd4;

  localparam logic signed [ACC_W-1:0] ONE_Q24 = 40'sd16777216;
  localparam logic [VAL_W-1:0] ONE_Q12 = 16'd4096;

  typedef enum logic [2:0] {
    CO_NONE,
    CO_START,
    CO_MAC,
    CO_SHIFT,
    CO_CLAMP
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     wr_weight;
    logic     wr_bias;
    logic     wr_input;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_CLAMP,
    ST_EMIT
  } state_e;

endpackage

### hdl/mlp_forward_pass.sv
// Top level: request decode, layer sequencer and the row of neuron cells.
// Usage:
//  Requests enter on start_i when busy_o is low; req_type_i selects a weight,
//  bias or input write, or a run. Writes give no result;
//  writes outside the current network are dropped.
//  A run copies the inputs into the cell row at the accepting edge, then for
//  each layer streams the previous activations down the row, one per cycle,
//  while every cell multiplies by its weight column and accumulates. Each
//  layer then drains the multiply pipeline and clamps. Results then leave
//  one per cycle on result_valid_o with out_index_o, activation_o and
//  last_o, busy_o staying high until the last one. The receiver cannot
//  stall: each result is shown for one cycle only.
//  Configuration writes on cfg_valid_i/cfg_ready_o are taken every cycle.
//  Reset clears biases and inputs to zero and restores the default sizes,
//  then a clearing pass over all (MAX_LAYERS-1)*MAX_NEURONS weight addresses
//  (48 by default) zeroes the weight memories while busy_o is high.
module mlp_forward_pass import mlp_pkg::*; #(
  parameter int MAX_NEURONS = 16,
  parameter int MAX_LAYERS  = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [1:0]           req_type_i,
  input  logic [1:0]           layer_sel_i,
  input  logic [3:0]           src_index_i,
  input  logic [3:0]           dst_index_i,
  input  logic signed [15:0]   value_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SIZE_W-1:0]    cfg_data_i,
  output logic                 result_valid_o,
  output logic [3:0]           out_index_o,
  output logic [ACT_W-1:0]     activation_o,
  output logic                 last_o
);

  localparam int NCAP = (MAX_NEURONS < 16) ? MAX_NEURONS : 16;
  localparam int HCAP = (MAX_LAYERS - 2 < 2) ? MAX_LAYERS - 2 : 2;
  localparam int WD   = (MAX_LAYERS-1)*MAX_NEURONS;
  localparam int AW   = $clog2(WD);
  localparam int BD   = (MAX_LAYERS > 2) ? MAX_LAYERS-1 : 2;
  localparam int BIW  = $clog2(BD);

  logic [SIZE_W-1:0] in_sz_q, h1_sz_q, h2_sz_q, out_sz_q;
  logic [1:0]        hl_q, eff_h, top_l;
  state_e            state_q, state_d;
  logic [1:0]        lay_q, lay_d;
  logic [SIZE_W-1:0] cnt_q, cnt_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic              accept, ok_w, ok_b, ok_i, clearing;
  logic [SIZE_W-1:0] p_sz, n_out;
  logic [AW-1:0]     waddr, raddr;
  logic [BIW-1:0]    b_widx, b_ridx;
  logic signed [VAL_W-1:0] wdata;
  cell_op_e          op;
  cell_ctl_t         ctl [MAX_NEURONS];
  logic signed [VAL_W-1:0] act [MAX_NEURONS+1];

  function automatic logic [SIZE_W-1:0] clamp_sz(input logic [SIZE_W-1:0] s);
    if (s == '0) begin
      return SIZE_W'(1);
    end else if (int'(s) > NCAP) begin
      return SIZE_W'(NCAP);
    end
    return s;
  endfunction

  function automatic logic [SIZE_W-1:0] size_of(input logic [2:0] l, input logic [1:0] t,
                                                input logic [SIZE_W-1:0] s0,
                                                input logic [SIZE_W-1:0] s1,
                                                input logic [SIZE_W-1:0] s2,
                                                input logic [SIZE_W-1:0] so);
    if (l == 3'd0) begin
      return clamp_sz(s0);
    end else if (l == {1'b0, t}) begin
      return clamp_sz(so);
    end else if (l == 3'd1) begin
      return clamp_sz(s1);
    end
    return clamp_sz(s2);
  endfunction

  assign eff_h = (int'(hl_q) > HCAP) ? 2'(HCAP) : hl_q;
  assign top_l = eff_h + 2'd1;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sz_q  <= 5'd16;
      hl_q     <= 2'd2;
      h1_sz_q  <= 5'd16;
      h2_sz_q  <= 5'd16;
      out_sz_q <= 5'd16;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_INPUT_SIZE:    in_sz_q  <= cfg_data_i;
        CFG_HIDDEN_LAYERS: hl_q     <= cfg_data_i[1:0];
        CFG_HIDDEN1_SIZE:  h1_sz_q  <= cfg_data_i;
        CFG_HIDDEN2_SIZE:  h2_sz_q  <= cfg_data_i;
        CFG_OUTPUT_SIZE:   out_sz_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign accept   = start_i && !busy_o;
  assign clearing = (state_q == ST_CLEAR);

  assign ok_w = ({1'b0, layer_sel_i} < {1'b0, top_l})
             && ({1'b0, src_index_i} < size_of({1'b0, layer_sel_i}, top_l, in_sz_q,
                                               h1_sz_q, h2_sz_q, out_sz_q))
             && ({1'b0, dst_index_i} < size_of({1'b0, layer_sel_i} + 3'd1, top_l, in_sz_q,
                                               h1_sz_q, h2_sz_q, out_sz_q));
  assign ok_b = (layer_sel_i != 2'd0) && (layer_sel_i <= top_l)
             && ({1'b0, dst_index_i} < size_of({1'b0, layer_sel_i}, top_l, in_sz_q,
                                               h1_sz_q, h2_sz_q, out_sz_q));
  assign ok_i = ({1'b0, src_index_i} < clamp_sz(in_sz_q));

  assign p_sz  = size_of({1'b0, lay_q - 2'd1}, top_l, in_sz_q, h1_sz_q, h2_sz_q, out_sz_q);
  assign n_out = clamp_sz(out_sz_q);

  assign waddr  = clearing ? clr_q
                           : AW'(int'(layer_sel_i) * MAX_NEURONS + int'(src_index_i));
  assign wdata  = clearing ? '0 : value_i;
  assign raddr  = AW'(int'(lay_q - 2'd1) * MAX_NEURONS + int'(cnt_q));
  assign b_widx = BIW'(layer_sel_i - 2'd1);
  assign b_ridx = (state_q == ST_IDLE) ? '0 : BIW'(lay_q);

  always_comb begin
    state_d = state_q;
    lay_d   = lay_q;
    cnt_d   = cnt_q;
    clr_d   = clr_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(WD - 1)) begin
          state_d = ST_IDLE;
          clr_d   = '0;
        end
      end
      ST_IDLE: begin
        if (accept && req_type_i == REQ_RUN) begin
          state_d = ST_MAC;
          lay_d   = 2'd1;
          cnt_d   = '0;
        end
      end
      ST_MAC: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == p_sz - 1'b1) begin
          state_d = ST_DRAIN;
          cnt_d   = '0;
        end
      end
      ST_DRAIN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SIZE_W'(1)) begin
          state_d = ST_CLAMP;
          cnt_d   = '0;
        end
      end
      ST_CLAMP: begin
        cnt_d = '0;
        if (lay_q == top_l) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_MAC;
          lay_d   = lay_q + 2'd1;
        end
      end
      ST_EMIT: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == n_out - 1'b1) begin
          state_d = ST_IDLE;
          cnt_d   = '0;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state_q)
      ST_IDLE:  op = (accept && req_type_i == REQ_RUN) ? CO_START : CO_NONE;
      ST_MAC:   op = CO_MAC;
      ST_CLAMP: op = CO_CLAMP;
      ST_EMIT:  op = CO_SHIFT;
      default:  op = CO_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      lay_q   <= 2'd1;
      cnt_q   <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      lay_q   <= lay_d;
      cnt_q   <= cnt_d;
      clr_q   <= clr_d;
    end
  end

  assign act[MAX_NEURONS] = '0;

  for (genvar k = 0; k < MAX_NEURONS; k++) begin : g_cell
    always_comb begin
      ctl[k].op        = op;
      ctl[k].wr_weight = clearing
                         || (accept && req_type_i == REQ_WEIGHT && ok_w
                             && int'(dst_index_i) == k);
      ctl[k].wr_bias   = accept && req_type_i == REQ_BIAS && ok_b
                         && int'(dst_index_i) == k;
      ctl[k].wr_input  = accept && req_type_i == REQ_INPUT && ok_i
                         && int'(src_index_i) == k;
    end

    mlp_cell #(.MAX_NEURONS(MAX_NEURONS), .MAX_LAYERS(MAX_LAYERS)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl[k]),
      .waddr_i   (waddr),
      .raddr_i   (raddr),
      .b_widx_i  (b_widx),
      .b_ridx_i  (b_ridx),
      .wdata_i   (wdata),
      .head_i    (act[0]),
      .next_act_i(act[k+1]),
      .act_o     (act[k])
    );
  end

  assign result_valid_o = (state_q == ST_EMIT);
  assign out_index_o    = cnt_q[3:0];
  assign activation_o   = act[0][ACT_W-1:0];
  assign last_o         = (state_q == ST_EMIT) && (cnt_q == n_out - 1'b1);

endmodule

### hdl/mlp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mlp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/mlp_cell.sv
// One neuron cell: weight column, biases, input value, MAC and clamp.
module mlp_cell import mlp_pkg::*; #(
  parameter int MAX_NEURONS = 16,
  parameter int MAX_LAYERS  = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cell_ctl_t               ctl_i,
  input  logic [$clog2((MAX_LAYERS-1)*MAX_NEURONS)-1:0] waddr_i,
  input  logic [$clog2((MAX_LAYERS-1)*MAX_NEURONS)-1:0] raddr_i,
  input  logic [$clog2((MAX_LAYERS > 2) ? MAX_LAYERS-1 : 2)-1:0] b_widx_i,
  input  logic [$clog2((MAX_LAYERS > 2) ? MAX_LAYERS-1 : 2)-1:0] b_ridx_i,
  input  logic signed [VAL_W-1:0] wdata_i,
  input  logic signed [VAL_W-1:0] head_i,
  input  logic signed [VAL_W-1:0] next_act_i,
  output logic signed [VAL_W-1:0] act_o
);

  localparam int WD = (MAX_LAYERS-1)*MAX_NEURONS;
  localparam int BD = (MAX_LAYERS > 2) ? MAX_LAYERS-1 : 2;

  logic [VAL_W-1:0]         rdata;
  logic signed [VAL_W-1:0]  in_q, act_q, x_q;
  logic signed [VAL_W-1:0]  bias_q [BD];
  logic                     v1_q, v2_q;
  logic signed [2*VAL_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d, bias_init;
  logic signed [VAL_W-1:0]  wsel, clamp_val;

  mlp_ram #(.WIDTH(VAL_W), .DEPTH(WD)) u_wram (
    .clk_i  (clk_i),
    .we_i   (ctl_i.wr_weight),
    .waddr_i(waddr_i),
    .wdata_i(wdata_i),
    .raddr_i(raddr_i),
    .rdata_o(rdata)
  );

  assign wsel = signed'(rdata);
  assign bias_init = {{(ACC_W-VAL_W-12){bias_q[b_ridx_i][VAL_W-1]}}, bias_q[b_ridx_i], 12'b0};

  always_comb begin
    if (acc_q <= 0) begin
      clamp_val = '0;
    end else if (acc_q >= ONE_Q24) begin
      clamp_val = signed'(ONE_Q12);
    end else begin
      clamp_val = signed'({3'b0, acc_q[24:12]});
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.op == CO_START || ctl_i.op == CO_CLAMP) begin
      acc_d = bias_init;
    end else if (v2_q) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q    <= '0;
      act_q   <= '0;
      x_q     <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      prod_q  <= '0;
      acc_q   <= '0;
      for (int i = 0; i < BD; i++) begin
        bias_q[i] <= '0;
      end
    end else begin
      if (ctl_i.wr_bias) begin
        bias_q[b_widx_i] <= wdata_i;
      end
      if (ctl_i.wr_input) begin
        in_q <= wdata_i;
      end
      x_q     <= head_i;
      v1_q    <= (ctl_i.op == CO_MAC);
      v2_q    <= v1_q;
      prod_q  <= x_q * wsel;
      acc_q   <= acc_d;
      case (ctl_i.op)
        CO_START:          act_q <= in_q;
        CO_CLAMP:          act_q <= clamp_val;
        CO_MAC, CO_SHIFT:  act_q <= next_act_i;
        default:           act_q <= act_q;
      endcase
    end
  end

  assign act_o = act_q;

endmodule
